[hw/rtl/hbmt_pkg.sv]
package hbmt_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// field widths
	localparam int ID_W   = 8;
	localparam int PORT_W = 8;
	localparam int HB_W   = 32;
	localparam int TM_W   = 32;
	localparam int WORD_W = 32;
	localparam int TO_W   = 16;
	localparam int EV_W   = 3;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SELF_ID = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(1);

	// register reset values
	localparam logic [ID_W-1:0] SELF_ID_RST = ID_W'(1);
	localparam logic [TO_W-1:0] TIMEOUT_RST = TO_W'(25);

	// input kinds
	localparam logic KIND_MERGE = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [EV_W-1:0] {
		EV_UNCHANGED = 3'd0,
		EV_ADDED     = 3'd1,
		EV_REFRESHED = 3'd2,
		EV_IGNORED   = 3'd3,
		EV_DROPPED   = 3'd4,
		EV_TIMEOUT   = 3'd5,
		EV_TICKDONE  = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		ALU_INC = 2'd0,
		ALU_SUB = 2'd1,
		ALU_GT  = 2'd2
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_RD,
		ST_M_CHK,
		ST_T_INC,
		ST_T_FRD,
		ST_T_FCHK,
		ST_T_SELF,
		ST_S_RD,
		ST_S_CHK,
		ST_S_CMP,
		ST_OUT
	} state_t;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PORT_W-1:0] port;
		logic [HB_W-1:0]   hb;
		logic [TM_W-1:0]   tm;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	// one result item
	typedef struct packed {
		event_t            ev;
		logic [ID_W-1:0]   id;
		logic [PORT_W-1:0] port;
		logic [HB_W-1:0]   hb;
		logic              last;
	} res_t;

endpackage

[hw/rtl/hbmt_if.sv]
// item channel
interface hbmt_item_if import hbmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [ID_W-1:0]   node_id;
	logic [PORT_W-1:0] node_port;
	logic [HB_W-1:0]   heartbeat;

	modport source (output valid, kind, node_id, node_port, heartbeat, input ready);
	modport sink (input valid, kind, node_id, node_port, heartbeat, output ready);
endinterface

// result channel
interface hbmt_result_if import hbmt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [EV_W-1:0]   event_res;
	logic [ID_W-1:0]   out_id;
	logic [PORT_W-1:0] out_port;
	logic [HB_W-1:0]   out_heartbeat;
	logic              last;

	modport source (output valid, event_res, out_id, out_port, out_heartbeat, last,
		input ready);
	modport sink (input valid, event_res, out_id, out_port, out_heartbeat, last,
		output ready);
endinterface

// configuration write channel
interface hbmt_cfg_if import hbmt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/hbmt_ram.sv]
module hbmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/hbmt_alu.sv]
module hbmt_alu import hbmt_pkg::*; (
	input  alu_op_t           op,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WORD_W-1:0] y
);

	// shared 32-bit increment / subtract / unsigned compare
	always_comb begin
		case (op)
			ALU_INC: y = a + WORD_W'(1);
			ALU_SUB: y = a - b;
			ALU_GT:  y = {{(WORD_W-1){1'b0}}, (a > b)};
			default: y = '0;
		endcase
	end

endmodule

[hw/rtl/heartbeat_membership_table_core.sv]
// Heartbeat membership table.
// item: one request per input; kind 0 merges (node_id, node_port, heartbeat)
// into the table, kind 1 is a time tick that ages the table.
// result: every merge gives one result with last = 1; a tick gives one result
// per member that timed out (last = 0, ascending slot order) and then a
// tick-done result with last = 1.
// cfg: register 0 is self_id, register 1 is removal_timeout; always ready.
// One request is worked at a time; item.ready is high only between requests.
// A sequencer walks the entry RAM one slot at a time through one shared
// 32-bit ALU. Merge: used slots are checked until the match, free slots are
// noted, and with no match the lowest free slot is taken. Tick: advance the
// time, find and bump the self entry, then sweep the other live slots.
// Results pass an output register; while the receiver stalls the sequencer
// waits before the next result and resumes when it drains.
// Reset clears the used and tombstone bits, the time and the output valid
// bit, and loads self_id = 1, removal_timeout = 25; no clearing pass is needed.
module heartbeat_membership_table_core import hbmt_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	hbmt_item_if.sink    item,
	hbmt_result_if.source result,
	hbmt_cfg_if.sink     cfg
);

	state_t state_q, state_d;

	logic [CNT_W-1:0] idx_q, idx_d;
	logic [IDX_W-1:0] idx_lo;
	logic             at_end;

	logic             free_vld_q, free_vld_d;
	logic [IDX_W-1:0] free_idx_q, free_idx_d;
	logic             self_vld_q, self_vld_d;
	logic [IDX_W-1:0] self_idx_q, self_idx_d;

	logic [TABLE_DEPTH-1:0] used_q, used_d;
	logic [TABLE_DEPTH-1:0] rem_q, rem_d;
	logic [TM_W-1:0]        ct_q, ct_d;

	logic [ID_W-1:0] self_id_q;
	logic [TO_W-1:0] timeout_q;

	logic [ID_W-1:0]   id_q;
	logic [PORT_W-1:0] port_q;
	logic [HB_W-1:0]   hb_q;

	ent_t              ent_q, ent_d;
	logic [WORD_W-1:0] diff_q, diff_d;
	logic [PORT_W-1:0] self_port_q, self_port_d;
	logic [HB_W-1:0]   self_hb_q, self_hb_d;
	res_t              res_q, res_d;

	logic out_vld_q;
	res_t out_q;
	logic out_load;
	logic slot_free;
	logic accept;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	ent_t             ram_wdata;
	logic [ENT_W-1:0] ram_rdata;
	ent_t             rd;

	alu_op_t           alu_op;
	logic [WORD_W-1:0] alu_a, alu_b, alu_y;

	assign idx_lo    = idx_q[IDX_W-1:0];
	assign at_end    = (idx_q == CNT_W'(TABLE_DEPTH));
	assign rd        = ent_t'(ram_rdata);
	assign slot_free = !out_vld_q || result.ready;
	assign accept    = item.valid && item.ready;

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;

	// entry storage
	hbmt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_lo),
		.rdata (ram_rdata)
	);

	// shared ALU operand select
	always_comb begin
		case (state_q)
			ST_T_INC: begin
				alu_op = ALU_INC;
				alu_a  = ct_q;
				alu_b  = '0;
			end
			ST_T_SELF: begin
				alu_op = ALU_INC;
				alu_a  = ent_q.hb;
				alu_b  = '0;
			end
			ST_S_CHK: begin
				alu_op = ALU_SUB;
				alu_a  = ct_q;
				alu_b  = rd.tm;
			end
			ST_S_CMP: begin
				alu_op = ALU_GT;
				alu_a  = diff_q;
				alu_b  = {{(WORD_W-TO_W){1'b0}}, timeout_q};
			end
			ST_M_CHK: begin
				alu_op = ALU_GT;
				alu_a  = hb_q;
				alu_b  = rd.hb;
			end
			default: begin
				alu_op = ALU_INC;
				alu_a  = '0;
				alu_b  = '0;
			end
		endcase
	end

	hbmt_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// sequencer: next state and strobes
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		free_vld_d  = free_vld_q;
		free_idx_d  = free_idx_q;
		self_vld_d  = self_vld_q;
		self_idx_d  = self_idx_q;
		used_d      = used_q;
		rem_d       = rem_q;
		ct_d        = ct_q;
		ent_d       = ent_q;
		diff_d      = diff_q;
		self_port_d = self_port_q;
		self_hb_d   = self_hb_q;
		res_d       = res_q;
		out_load    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = idx_lo;
		ram_wdata   = '{id: id_q, port: port_q, hb: hb_q, tm: ct_q};

		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					idx_d      = '0;
					free_vld_d = 1'b0;
					self_vld_d = 1'b0;
					state_d    = (item.kind == KIND_TICK) ? ST_T_INC : ST_M_RD;
				end
			end

			// merge: search for (id, port), note the lowest free slot
			ST_M_RD: begin
				if (at_end) begin
					state_d = ST_OUT;
					if (free_vld_q) begin
						ram_we             = 1'b1;
						ram_waddr          = free_idx_q;
						used_d[free_idx_q] = 1'b1;
						rem_d[free_idx_q]  = 1'b0;
						res_d = '{ev: EV_ADDED, id: id_q, port: port_q, hb: hb_q, last: 1'b1};
					end else begin
						res_d = '{ev: EV_DROPPED, id: id_q, port: port_q, hb: hb_q, last: 1'b1};
					end
				end else if (used_q[idx_lo]) begin
					state_d = ST_M_CHK;
				end else begin
					if (!free_vld_q) begin
						free_vld_d = 1'b1;
						free_idx_d = idx_lo;
					end
					idx_d = idx_q + CNT_W'(1);
				end
			end

			ST_M_CHK: begin
				if (rd.id == id_q && rd.port == port_q) begin
					state_d = ST_OUT;
					if (rem_q[idx_lo]) begin
						res_d = '{ev: EV_IGNORED, id: id_q, port: port_q, hb: rd.hb, last: 1'b1};
					end else if (alu_y[0]) begin
						ram_we = 1'b1;
						res_d  = '{ev: EV_REFRESHED, id: id_q, port: port_q, hb: hb_q,
							last: 1'b1};
					end else begin
						res_d = '{ev: EV_UNCHANGED, id: id_q, port: port_q, hb: rd.hb,
							last: 1'b1};
					end
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_M_RD;
				end
			end

			// tick: advance time, then find the self entry
			ST_T_INC: begin
				ct_d    = alu_y;
				state_d = ST_T_FRD;
			end

			ST_T_FRD: begin
				if (at_end) begin
					idx_d   = '0;
					state_d = ST_S_RD;
				end else if (used_q[idx_lo] && !rem_q[idx_lo]) begin
					state_d = ST_T_FCHK;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end

			ST_T_FCHK: begin
				if (rd.id == self_id_q) begin
					self_vld_d = 1'b1;
					self_idx_d = idx_lo;
					ent_d      = rd;
					state_d    = ST_T_SELF;
				end else begin
					idx_d   = idx_q + CNT_W'(1);
					state_d = ST_T_FRD;
				end
			end

			// bump own heartbeat and stamp the new time
			ST_T_SELF: begin
				ram_we      = 1'b1;
				ram_waddr   = self_idx_q;
				ram_wdata   = '{id: ent_q.id, port: ent_q.port, hb: alu_y, tm: ct_q};
				self_port_d = ent_q.port;
				self_hb_d   = alu_y;
				idx_d       = '0;
				state_d     = ST_S_RD;
			end

			// sweep: tombstone every other live entry past the timeout
			ST_S_RD: begin
				if (at_end) begin
					state_d = ST_OUT;
					res_d   = '{ev: EV_TICKDONE, id: self_id_q,
						port: self_vld_q ? self_port_q : '0,
						hb: self_vld_q ? self_hb_q : '0, last: 1'b1};
				end else if (used_q[idx_lo] && !rem_q[idx_lo]
						&& !(self_vld_q && self_idx_q == idx_lo)) begin
					state_d = ST_S_CHK;
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end

			ST_S_CHK: begin
				ent_d   = rd;
				diff_d  = alu_y;
				state_d = ST_S_CMP;
			end

			ST_S_CMP: begin
				idx_d = idx_q + CNT_W'(1);
				if (alu_y[0]) begin
					rem_d[idx_lo] = 1'b1;
					res_d = '{ev: EV_TIMEOUT, id: ent_q.id, port: ent_q.port, hb: ent_q.hb,
						last: 1'b0};
					state_d = ST_OUT;
				end else begin
					state_d = ST_S_RD;
				end
			end

			// hand the result to the output register
			ST_OUT: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = res_q.last ? ST_IDLE : ST_S_RD;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			free_vld_q <= 1'b0;
			self_vld_q <= 1'b0;
			used_q     <= '0;
			rem_q      <= '0;
			ct_q       <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			idx_q      <= idx_d;
			free_vld_q <= free_vld_d;
			self_vld_q <= self_vld_d;
			used_q     <= used_d;
			rem_q      <= rem_d;
			ct_q       <= ct_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= SELF_ID_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SELF_ID: self_id_q <= cfg.data[ID_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg.data[TO_W-1:0];
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q   <= item.node_id;
			port_q <= item.node_port;
			hb_q   <= item.heartbeat;
		end
		free_idx_q  <= free_idx_d;
		self_idx_q  <= self_idx_d;
		ent_q       <= ent_d;
		diff_q      <= diff_d;
		self_port_q <= self_port_d;
		self_hb_q   <= self_hb_d;
		res_q       <= res_d;
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.event_res     = EV_W'(out_q.ev);
	assign result.out_id        = out_q.id;
	assign result.out_port      = out_q.port;
	assign result.out_heartbeat = out_q.hb;
	assign result.last          = out_q.last;

`ifndef SYNTHESIS
	// an accepted request always starts the sequencer
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted request did not start the sequencer");

	// slots are never freed
	a_used_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(used_q) & ~used_q) == '0)
		else $error("used slot was released");

	// a tombstone only sits on a used slot
	a_rem_in_used: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q & ~used_q) == '0)
		else $error("tombstone on an unused slot");

	// only timeout results are not the last of their request
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (res_q.last == (res_q.ev != EV_TIMEOUT)))
		else $error("last flag does not match the result kind");

	// the slot counter stays within the table
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= CNT_W'(TABLE_DEPTH))
		else $error("slot counter ran past the table");
`endif

endmodule

[tb/sv/membership_checker.sv]
`timescale 1ns / 100ps

// Watches the three channels, keeps its own copy of the membership table and
// compares every result request with the oldest predicted one.
module membership_checker import hbmt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	hbmt_item_if          item,
	hbmt_result_if        result,
	hbmt_cfg_if           cfg,
	output int            mismatches,
	output int            outstanding
);

	// shadow table
	bit                tbl_used[TABLE_DEPTH];
	bit                tbl_tomb[TABLE_DEPTH];
	logic [ID_W-1:0]   tbl_id[TABLE_DEPTH];
	logic [PORT_W-1:0] tbl_port[TABLE_DEPTH];
	logic [HB_W-1:0]   tbl_hb[TABLE_DEPTH];
	logic [TM_W-1:0]   tbl_tm[TABLE_DEPTH];
	logic [TM_W-1:0]   now_tm;

	// shadow registers
	logic [ID_W-1:0]   cur_self;
	logic [TO_W-1:0]   cur_timeout;

	// results predicted but not yet seen
	res_t              predicted_results[$];

	task automatic push_outcome(input event_t ev, input logic [ID_W-1:0] id,
		input logic [PORT_W-1:0] port, input logic [HB_W-1:0] hb, input logic last);
		res_t r;
		r.ev   = ev;
		r.id   = id;
		r.port = port;
		r.hb   = hb;
		r.last = last;
		predicted_results = {predicted_results, r};
	endtask

	// merge one member: match on (id, port), else lowest free slot
	task automatic merge_member(input logic [ID_W-1:0] id, input logic [PORT_W-1:0] port,
		input logic [HB_W-1:0] hb);
		int free_slot;
		int hit;
		free_slot = -1;
		hit       = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!tbl_used[i]) begin
				if (free_slot < 0)
					free_slot = i;
			end else if (hit < 0 && tbl_id[i] == id && tbl_port[i] == port) begin
				hit = i;
			end
		end
		if (hit >= 0) begin
			if (tbl_tomb[hit]) begin
				push_outcome(EV_IGNORED, id, port, tbl_hb[hit], 1'b1);
			end else if (hb > tbl_hb[hit]) begin
				tbl_hb[hit] = hb;
				tbl_tm[hit] = now_tm;
				push_outcome(EV_REFRESHED, id, port, hb, 1'b1);
			end else begin
				push_outcome(EV_UNCHANGED, id, port, tbl_hb[hit], 1'b1);
			end
		end else if (free_slot < 0) begin
			push_outcome(EV_DROPPED, id, port, hb, 1'b1);
		end else begin
			tbl_used[free_slot] = 1'b1;
			tbl_tomb[free_slot] = 1'b0;
			tbl_id[free_slot]   = id;
			tbl_port[free_slot] = port;
			tbl_hb[free_slot]   = hb;
			tbl_tm[free_slot]   = now_tm;
			push_outcome(EV_ADDED, id, port, hb, 1'b1);
		end
	endtask

	// tick: advance time, bump own heartbeat, tombstone silent members
	task automatic advance_tick();
		int              self_slot;
		logic [TM_W-1:0] silence;
		self_slot = -1;
		now_tm    = now_tm + 1'b1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (self_slot < 0 && tbl_used[i] && !tbl_tomb[i] && tbl_id[i] == cur_self)
				self_slot = i;
		end
		if (self_slot >= 0) begin
			tbl_hb[self_slot] = tbl_hb[self_slot] + 1'b1;
			tbl_tm[self_slot] = now_tm;
		end
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			silence = now_tm - tbl_tm[i];
			if (tbl_used[i] && !tbl_tomb[i] && i != self_slot && silence > TM_W'(cur_timeout)) begin
				tbl_tomb[i] = 1'b1;
				push_outcome(EV_TIMEOUT, tbl_id[i], tbl_port[i], tbl_hb[i], 1'b0);
			end
		end
		if (self_slot >= 0)
			push_outcome(EV_TICKDONE, cur_self, tbl_port[self_slot], tbl_hb[self_slot], 1'b1);
		else
			push_outcome(EV_TICKDONE, cur_self, '0, '0, 1'b1);
	endtask

	// compare one accepted result with the oldest prediction
	task automatic check_result();
		res_t want;
		if (predicted_results.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result with nothing predicted: ev %0d id %0h port %0h hb %0h last %0b",
					$realtime, result.event_res, result.out_id, result.out_port,
					result.out_heartbeat, result.last);
			mismatches++;
		end else begin
			want = predicted_results.pop_front();
			if (result.event_res !== want.ev || result.out_id !== want.id ||
					result.out_port !== want.port || result.out_heartbeat !== want.hb ||
					result.last !== want.last) begin
				if (mismatches < 10)
					$display({"%0t: mismatch: expected ev %0d id %0h port %0h hb %0h last %0b,",
						" got ev %0d id %0h port %0h hb %0h last %0b"}, $realtime,
						want.ev, want.id, want.port, want.hb, want.last,
						result.event_res, result.out_id, result.out_port,
						result.out_heartbeat, result.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				tbl_used[i] = 1'b0;
				tbl_tomb[i] = 1'b0;
				tbl_id[i]   = '0;
				tbl_port[i] = '0;
				tbl_hb[i]   = '0;
				tbl_tm[i]   = '0;
			end
			now_tm      = '0;
			cur_self    = SELF_ID_RST;
			cur_timeout = TIMEOUT_RST;
			predicted_results.delete();
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			// register writes
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SELF_ID)
					cur_self = cfg.data[ID_W-1:0];
				else if (cfg.index == REG_TIMEOUT)
					cur_timeout = cfg.data[TO_W-1:0];
			end
			// results belong to earlier requests, so check before predicting
			if (result.valid && result.ready)
				check_result();
			if (item.valid && item.ready) begin
				if (item.kind == KIND_TICK)
					advance_tick();
				else
					merge_member(item.node_id, item.node_port, item.heartbeat);
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import hbmt_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hbmt_item_if   item_ch ();
	hbmt_result_if result_ch ();
	hbmt_cfg_if    cfg_ch ();

	int mismatches;
	int outstanding;

	// traffic shaping
	bit idle_on  = 1'b0;
	bit stall_on = 1'b0;
	int hold_asks = 0;
	int hold_seen = 0;

	// members the random part draws from
	logic [ID_W-1:0]   pool_id[$];
	logic [PORT_W-1:0] pool_port[$];
	logic [HB_W-1:0]   pool_hb[$];

	heartbeat_membership_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	membership_checker scorer (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls and one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// offer one request; valid stays high until the caller drops it
	task automatic offer_request(input logic kind, input logic [ID_W-1:0] id,
		input logic [PORT_W-1:0] port, input logic [HB_W-1:0] hb);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.kind      <= kind;
		item_ch.node_id   <= id;
		item_ch.node_port <= port;
		item_ch.heartbeat <= hb;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	// tick with junk in the unused fields
	task automatic send_tick();
		offer_request(KIND_TICK, ID_W'($urandom), PORT_W'($urandom), $urandom);
	endtask

	// stop offering until every predicted result has arrived
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers plus an unmapped index; stray high bits on self_id
	task automatic set_registers(input logic [ID_W-1:0] self_val,
		input logic [TO_W-1:0] timeout_val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_SELF_ID;
		cfg_ch.data  <= {(CFG_DATA_W-ID_W)'($urandom), self_val};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= REG_TIMEOUT;
		cfg_ch.data  <= CFG_DATA_W'(timeout_val);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= CFG_IDX_W'($urandom_range(int'(REG_TIMEOUT) + 1, (1 << CFG_IDX_W) - 1));
		cfg_ch.data  <= CFG_DATA_W'($urandom);
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic add_to_pool(input logic [ID_W-1:0] id, input logic [PORT_W-1:0] port);
		pool_id   = {pool_id, id};
		pool_port = {pool_port, port};
		pool_hb   = {pool_hb, HB_W'($urandom_range(0, 1000))};
	endtask

	task automatic clear_pool();
		pool_id.delete();
		pool_port.delete();
		pool_hb.delete();
	endtask

	// random merges on the pool, random ticks, optional unknown members;
	// pauses once mid-way until the table has answered everything
	task automatic play_phase(input int count, input int tick_pct, input bit wild_ids);
		int              k;
		int              mode;
		logic [HB_W-1:0] hb;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				settle();
			if ($urandom_range(0, 99) < tick_pct) begin
				send_tick();
			end else if (wild_ids && $urandom_range(0, 3) == 0) begin
				offer_request(KIND_MERGE, ID_W'($urandom), PORT_W'($urandom), $urandom);
			end else begin
				k    = $urandom_range(0, pool_id.size() - 1);
				mode = $urandom_range(0, 3);
				if (mode < 2) begin
					hb = pool_hb[k] + HB_W'($urandom_range(1, 4));
					pool_hb[k] = hb;
				end else if (mode == 2) begin
					hb = pool_hb[k] - HB_W'($urandom_range(0, 2));
				end else begin
					hb = $urandom;
				end
				offer_request(KIND_MERGE, pool_id[k], pool_port[k], hb);
			end
		end
	endtask

	initial begin
		item_ch.valid     <= 1'b0;
		item_ch.kind      <= KIND_MERGE;
		item_ch.node_id   <= '0;
		item_ch.node_port <= '0;
		item_ch.heartbeat <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_SELF_ID;
		cfg_ch.data       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty tick, own heartbeat wrap, refresh rules, field extremes
		send_tick();
		offer_request(KIND_MERGE, 8'd1, 8'd7, 32'hFFFF_FFFF);
		send_tick();
		offer_request(KIND_MERGE, 8'd1, 8'd7, 32'd5);
		offer_request(KIND_MERGE, 8'd1, 8'd7, 32'd5);
		offer_request(KIND_MERGE, 8'd1, 8'd7, 32'd0);
		offer_request(KIND_MERGE, 8'd0, 8'd0, 32'd0);
		offer_request(KIND_MERGE, 8'd255, 8'd255, 32'hFFFF_FFFF);
		offer_request(KIND_MERGE, 8'd255, 8'd255, 32'd0);
		// same id as this node on another port: swept like any other
		offer_request(KIND_MERGE, 8'd1, 8'd9, 32'd3);
		offer_request(KIND_MERGE, 8'd0, 8'd255, 32'd1);
		offer_request(KIND_MERGE, 8'd255, 8'd0, 32'd2);
		send_tick();
		settle();

		// zero timeout: every unrefreshed live member goes in one sweep
		set_registers(8'd1, 16'd0);
		send_tick();
		offer_request(KIND_MERGE, 8'd0, 8'd0, 32'd9);
		offer_request(KIND_MERGE, 8'd1, 8'd9, 32'd4);
		offer_request(KIND_MERGE, 8'd1, 8'd7, 32'd6);
		offer_request(KIND_MERGE, 8'd200, 8'd100, 32'd7);
		send_tick();
		settle();

		// widest timeout, stalls on both sides, long hold-off on results
		idle_on  = 1'b1;
		stall_on <= 1'b1;
		set_registers(8'd1, 16'hFFFF);
		clear_pool();
		add_to_pool(8'd1, 8'd7);
		add_to_pool(8'd0, 8'd0);
		add_to_pool(8'd16, 8'd1);
		add_to_pool(8'd16, 8'd2);
		add_to_pool(8'd40, 8'd200);
		add_to_pool(8'd128, 8'd128);
		add_to_pool(8'd255, 8'd255);
		hold_asks <= hold_asks + 1;
		play_phase(140, 20, 1'b0);
		settle();

		// short timeout, new own id: members age out unless refreshed
		set_registers(8'd40, 16'd3);
		clear_pool();
		add_to_pool(8'd1, 8'd7);
		add_to_pool(8'd40, 8'd200);
		add_to_pool(8'd16, 8'd1);
		add_to_pool(8'd128, 8'd128);
		add_to_pool(8'd99, 8'd5);
		add_to_pool(8'd99, 8'd6);
		add_to_pool(8'd1, 8'd9);
		play_phase(110, 40, 1'b0);
		settle();

		// highest own id with zero timeout
		set_registers(8'd255, 16'd0);
		clear_pool();
		add_to_pool(8'd255, 8'd31);
		add_to_pool(8'd255, 8'd32);
		add_to_pool(8'd40, 8'd200);
		add_to_pool(8'd16, 8'd2);
		play_phase(40, 30, 1'b0);
		settle();

		// lowest own id, table fills with unknown members; no idling
		idle_on  = 1'b0;
		stall_on <= 1'b0;
		set_registers(8'd0, 16'd1);
		clear_pool();
		add_to_pool(8'd0, 8'd77);
		add_to_pool(8'd0, 8'd78);
		add_to_pool(8'd255, 8'd31);
		play_phase(80, 25, 1'b1);
		settle();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
